[src/scts_pkg.sv]
package scts_pkg;

	localparam int MaxTermsDef = 24;
	localparam int FracBitsDef = 30;
	localparam int AngleW = 32;
	localparam int TolW = 31;
	localparam int ValueW = 32;
	localparam logic [63:0] PiQ62 = 64'hC90FDAA22168C235;

	typedef struct packed {
		logic              kind;
		logic signed [31:0] angle;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               capped;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_FOLD,
		ST_SQUARE,
		ST_INIT,
		ST_CHECK,
		ST_MUL,
		ST_DIV,
		ST_ROUND,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic red_step;
		logic fold;
		logic square;
		logic init;
		logic mul_start;
		logic mul_step;
		logic div_start;
		logic div_step;
		logic term_round;
		logic finish;
		logic set_cap;
	} cmd_t;

	typedef struct packed {
		logic red_last;
		logic mul_last;
		logic div_last;
		logic above_tol;
		logic at_cap;
	} status_t;

endpackage

[src/scts_datapath.sv]
module scts_datapath #(
	parameter int MAX_TERMS = scts_pkg::MaxTermsDef,
	parameter int FRAC_BITS = scts_pkg::FracBitsDef
) (
	input  logic                   clk,
	input  scts_pkg::cmd_t         cmd,
	output scts_pkg::status_t      sts,
	input  scts_pkg::in_beat_t     in_beat,
	input  logic [scts_pkg::TolW-1:0] tol,
	output scts_pkg::out_beat_t    result
);
	import scts_pkg::*;

	localparam int RedSteps = 3;
	localparam int RedCntW = $clog2(RedSteps);
	localparam int QW = 16;
	localparam int CntW = $clog2(MAX_TERMS + 1);
	localparam int DW = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS + 1) + 1);
	localparam int DivCntW = $clog2(128 + 1);
	localparam logic [63:0] PiF = 64'((PiQ62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
	localparam logic [63:0] TwoPiF = 64'((PiQ62 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS));
	localparam logic [31:0] RecipM = 32'((128'd1 << (FRAC_BITS + 32)) / {64'd0, TwoPiF});

	logic               cos_q;
	logic               xneg_q;
	logic [31:0]        amag_q;
	logic [63:0]        r_q;
	logic [RedCntW-1:0] rcnt_q;
	logic [QW-1:0]      rq_q;
	logic [127:0]       qt_q;
	logic [63:0]        xm_q;
	logic [63:0]        x2_q;
	logic [63:0]        tmag_q;
	logic               tneg_q;
	logic [63:0]        sum_q;
	logic [CntW-1:0]    count_q;
	logic [DW-1:0]      d_q;
	logic [DW-1:0]      dn_q;
	logic [127:0]       prod_q;
	logic [63:0]        mcand_q;
	logic [63:0]        mplier_q;
	logic [1:0]         mcnt_q;
	logic [127:0]       quo_q;
	logic [DW-1:0]      rem_q;
	logic [DivCntW-1:0] dcnt_q;
	logic               capped_q;
	out_beat_t          result_q;

	logic [63:0]        rq_prod;
	logic [127:0]       qt_full;
	logic [127:0]       red_n;
	logic [127:0]       red_diff;
	logic [DW:0]        rem_sh;
	logic [127:0]       rnd;
	logic [63:0]        tq30;
	logic [63:0]        smag;
	logic [63:0]        res;
	logic [63:0]        mul_part;
	logic [127:0]       mul_next;

	// The quotient estimate from the reciprocal is exact or one short.
	assign rq_prod = {32'd0, amag_q} * {32'd0, RecipM};
	assign qt_full = {112'd0, rq_q} * {64'd0, TwoPiF};
	assign red_n = {96'd0, amag_q} << (FRAC_BITS - 16);
	assign red_diff = red_n - qt_q;
	assign rem_sh = {rem_q, quo_q[127]};
	assign rnd = quo_q + (128'd1 << (FRAC_BITS - 1));
	assign mul_part = (mplier_q >> (mcnt_q * 16)) & 64'hFFFF;
	assign mul_next = prod_q + (({64'd0, mcand_q} * {112'd0, mul_part[15:0]}) << (mcnt_q * 16));

	always_comb begin
		if (FRAC_BITS >= 30) begin
			tq30 = tmag_q >> (FRAC_BITS - 30);
		end else begin
			tq30 = tmag_q << (30 - FRAC_BITS);
		end
		smag = sum_q[63] ? (64'd0 - sum_q) : sum_q;
		if (FRAC_BITS > 30) begin
			res = (smag + (64'd1 << (FRAC_BITS - 31))) >> (FRAC_BITS - 30);
		end else begin
			res = smag << (30 - FRAC_BITS);
		end
		if (res > (64'd1 << 30)) begin
			res = 64'd1 << 30;
		end
	end

	assign sts.red_last = (rcnt_q == RedCntW'(RedSteps - 1));
	assign sts.mul_last = (mcnt_q == 2'd3);
	assign sts.div_last = (dcnt_q == DivCntW'(127));
	assign sts.above_tol = (tq30 > {33'd0, tol});
	assign sts.at_cap = (count_q >= CntW'(MAX_TERMS));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cos_q <= in_beat.kind;
			xneg_q <= in_beat.angle[31];
			amag_q <= in_beat.angle[31] ? (32'd0 - in_beat.angle) : in_beat.angle;
			r_q <= '0;
			rcnt_q <= '0;
		end
		if (cmd.red_step) begin
			if (rcnt_q == RedCntW'(0)) begin
				rq_q <= QW'(rq_prod >> 48);
			end else if (rcnt_q == RedCntW'(1)) begin
				qt_q <= qt_full;
			end else begin
				r_q <= (red_diff >= {64'd0, TwoPiF}) ? 64'(red_diff - {64'd0, TwoPiF})
				                                     : red_diff[63:0];
			end
			rcnt_q <= rcnt_q + 1'b1;
		end
		if (cmd.fold) begin
			if (r_q > PiF) begin
				xm_q <= TwoPiF - r_q;
				xneg_q <= !xneg_q;
			end else begin
				xm_q <= r_q;
			end
		end
		if (cmd.square) begin
			mcand_q <= xm_q;
			mplier_q <= xm_q;
			prod_q <= '0;
			mcnt_q <= '0;
		end
		if (cmd.mul_start) begin
			mcand_q <= tmag_q;
			mplier_q <= x2_q;
			prod_q <= '0;
			mcnt_q <= '0;
		end
		if (cmd.mul_step) begin
			prod_q <= mul_next;
			mcnt_q <= mcnt_q + 1'b1;
		end
		if (cmd.init) begin
			x2_q <= 64'((prod_q + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
			count_q <= CntW'(1);
			d_q <= cos_q ? DW'(2) : DW'(6);
			dn_q <= cos_q ? DW'(10) : DW'(14);
			capped_q <= 1'b0;
			if (cos_q) begin
				tmag_q <= 64'd1 << FRAC_BITS;
				tneg_q <= 1'b0;
				sum_q <= 64'd1 << FRAC_BITS;
			end else begin
				tmag_q <= xm_q;
				tneg_q <= xneg_q;
				sum_q <= xneg_q ? (64'd0 - xm_q) : xm_q;
			end
		end
		if (cmd.div_start) begin
			quo_q <= mul_next;
			rem_q <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_sh >= {1'b0, d_q}) begin
				rem_q <= DW'(rem_sh - {1'b0, d_q});
				quo_q <= {quo_q[126:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				quo_q <= {quo_q[126:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.term_round) begin
			tmag_q <= 64'(rnd >> FRAC_BITS);
			tneg_q <= !tneg_q;
			sum_q <= tneg_q ? (sum_q + 64'(rnd >> FRAC_BITS))
			                : (sum_q - 64'(rnd >> FRAC_BITS));
			count_q <= count_q + 1'b1;
			d_q <= d_q + dn_q;
			dn_q <= dn_q + DW'(8);
		end
		if (cmd.set_cap) begin
			capped_q <= 1'b1;
		end
		if (cmd.finish) begin
			result_q.value <= sum_q[63] ? (32'd0 - res[31:0]) : res[31:0];
			result_q.capped <= capped_q;
		end
	end

	assign result = result_q;

endmodule

[src/scts_ctrl.sv]
module scts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  scts_pkg::status_t sts,
	output scts_pkg::cmd_t    cmd
);
	import scts_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   sq_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nx = ST_REDUCE;
			ST_REDUCE: if (sts.red_last) state_nx = ST_FOLD;
			ST_FOLD:   state_nx = ST_SQUARE;
			ST_SQUARE: state_nx = ST_MUL;
			ST_INIT:   state_nx = ST_CHECK;
			ST_CHECK: begin
				if (!sts.above_tol) state_nx = ST_FINISH;
				else if (sts.at_cap) state_nx = ST_FINISH;
				else state_nx = ST_MUL;
			end
			ST_MUL: begin
				if (sts.mul_last) state_nx = sq_q ? ST_INIT : ST_DIV;
			end
			ST_DIV:    if (sts.div_last) state_nx = ST_ROUND;
			ST_ROUND:  state_nx = ST_CHECK;
			ST_FINISH: state_nx = ST_OUT;
			ST_OUT:    if (out_ready) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_REDUCE: cmd.red_step = 1'b1;
			ST_FOLD:   cmd.fold = 1'b1;
			ST_SQUARE: cmd.square = 1'b1;
			ST_INIT:   cmd.init = 1'b1;
			ST_CHECK: begin
				cmd.mul_start = sts.above_tol && !sts.at_cap;
				cmd.set_cap = sts.above_tol && sts.at_cap;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				cmd.div_start = sts.mul_last && !sq_q;
			end
			ST_DIV:    cmd.div_step = 1'b1;
			ST_ROUND:  cmd.term_round = 1'b1;
			ST_FINISH: cmd.finish = 1'b1;
			ST_OUT:    out_valid = 1'b1;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sq_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_SQUARE) sq_q <= 1'b1;
			if (state_q == ST_INIT) sq_q <= 1'b0;
		end
	end

endmodule

[src/sin_cos_taylor_series.sv]
// Sine or cosine of a Q16.16 angle in Q2.30 by Taylor series, one item at a
// time. The angle is reduced modulo two pi by a reciprocal multiplication and
// one correcting subtraction, then folded and squared, and then the first term
// is tested. Each further term uses a 64x16-bit multiplier, a one-bit-a-cycle
// divider, rounding and the test. There are at most MAX_TERMS - 1 further
// terms, and the next input beat can be taken in the cycle after the result
// beat is accepted.
module sin_cos_taylor_series #(
	parameter int MAX_TERMS = scts_pkg::MaxTermsDef,
	parameter int FRAC_BITS = scts_pkg::FracBitsDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  scts_pkg::in_beat_t        in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output scts_pkg::out_beat_t       out_data,
	input  logic                      cfg_we,
	input  logic [scts_pkg::TolW-1:0] cfg_wdata
);
	import scts_pkg::*;

	cmd_t            cmd;
	status_t         sts;
	logic [TolW-1:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TolW'(1);
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	scts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	scts_datapath #(
		.MAX_TERMS (MAX_TERMS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.sts     (sts),
		.in_beat (in_data),
		.tol     (tol_q),
		.result  (out_data)
	);

endmodule

[src/scts_checker.sv]
module scts_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input scts_pkg::out_beat_t out_data
);
	import scts_pkg::*;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while a beat waits");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.value <= 32'sd1073741824 &&
		out_data.value >= -32'sd1073741824)) else $error("result out of range");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("no work after accepted beat");

endmodule

bind sin_cos_taylor_series scts_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
